// ===== rtl/owbm_pkg.sv =====
// shared types and constants for the 1-wire byte master
`timescale 1ns / 1ps

package owbm_pkg;

    localparam int unsigned InTdataW  = 16;
    localparam int unsigned OutTdataW = 16;
    localparam int unsigned CfgIdxW   = 3;
    localparam int unsigned CfgDataW  = 10;
    localparam int unsigned TickW     = 10;

    typedef enum logic [1:0] {
        OP_RESET = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        REG_IDLE_HIGH    = 3'd0,
        REG_RESET_LOW    = 3'd1,
        REG_PRES_WAIT    = 3'd2,
        REG_REL_WAIT     = 3'd3,
        REG_SLOT_LOW     = 3'd4,
        REG_WRITE_HOLD   = 3'd5,
        REG_READ_SAMPLE  = 3'd6,
        REG_READ_RECOVER = 3'd7
    } t_reg_idx;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_RHIGH  = 4'd1,
        PH_RLOW   = 4'd2,
        PH_PRES   = 4'd3,
        PH_REL    = 4'd4,
        PH_WLOW   = 4'd5,
        PH_WHOLD  = 4'd6,
        PH_RDLOW  = 4'd7,
        PH_RDWAIT = 4'd8,
        PH_RDREC  = 4'd9
    } t_phase;

    typedef struct packed {
        logic [3:0] idle_high_ticks;
        logic [9:0] reset_low_ticks;
        logic [7:0] presence_wait_limit;
        logic [7:0] release_wait_limit;
        logic [3:0] slot_low_ticks;
        logic [7:0] write_hold_ticks;
        logic [3:0] read_sample_ticks;
        logic [7:0] read_recovery_ticks;
    } t_cfg;

    localparam t_cfg CfgReset = '{
        idle_high_ticks:     4'd2,
        reset_low_ticks:     10'd480,
        presence_wait_limit: 8'd200,
        release_wait_limit:  8'd100,
        slot_low_ticks:      4'd3,
        write_hold_ticks:    8'd55,
        read_sample_ticks:   4'd3,
        read_recovery_ticks: 8'd45
    };

    typedef struct packed {
        logic       start_req;
        logic [1:0] operation;
        logic [7:0] write_data;
        logic       line_level;
    } t_item;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic       presence_ok;
        logic [7:0] read_data;
    } t_res;

endpackage

// ===== rtl/owbm_core.sv =====
// per-tick bus sequencer: phase, tick counter, bit shifter and result fields
`timescale 1ns / 1ps

module owbm_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  owbm_pkg::t_cfg  i_cfg,
    input  owbm_pkg::t_item i_item,
    output owbm_pkg::t_res  o_res
);
    import owbm_pkg::*;

    t_phase          r_phase, n_phase;
    logic [TickW-1:0] r_tc, n_tc;
    logic [2:0]      r_bit_idx, n_bit_idx;
    logic [7:0]      r_shift, n_shift;
    logic            r_pres, n_pres;
    logic [7:0]      r_rd_byte, n_rd_byte;

    t_phase          s_ph;
    logic [TickW-1:0] s_tc;
    logic [2:0]      s_bi;
    logic [7:0]      s_sd;
    logic            cmd_ok;
    logic [TickW-1:0] len_raw, len_eff, tc_inc;
    logic            tm_done;
    logic            pres_hit, pres_fail, rel_hit, rel_fail;
    logic [7:0]      rd_sd;
    logic            last_bit;
    logic            drive, done;

    // command pickup while idle
    always_comb begin
        cmd_ok = i_item.start_req && (i_item.operation == OP_RESET ||
                 i_item.operation == OP_WRITE || i_item.operation == OP_READ);
        s_ph = r_phase;
        s_tc = r_tc;
        s_bi = r_bit_idx;
        s_sd = r_shift;
        if (r_phase == PH_IDLE && cmd_ok) begin
            s_tc = '0;
            s_bi = '0;
            case (i_item.operation)
                OP_RESET: begin
                    s_sd = '0;
                    s_ph = (i_cfg.idle_high_ticks != '0) ? PH_RHIGH : PH_RLOW;
                end
                OP_WRITE: begin
                    s_sd = i_item.write_data;
                    s_ph = PH_WLOW;
                end
                default: begin
                    s_sd = '0;
                    s_ph = PH_RDLOW;
                end
            endcase
        end
    end

    // shared phase timer compare
    always_comb begin
        case (s_ph)
            PH_RHIGH:  len_raw = TickW'(i_cfg.idle_high_ticks);
            PH_RLOW:   len_raw = i_cfg.reset_low_ticks;
            PH_WLOW,
            PH_RDLOW:  len_raw = TickW'(i_cfg.slot_low_ticks);
            PH_WHOLD:  len_raw = TickW'(i_cfg.write_hold_ticks);
            PH_RDWAIT: len_raw = TickW'(i_cfg.read_sample_ticks);
            PH_RDREC:  len_raw = TickW'(i_cfg.read_recovery_ticks);
            default:   len_raw = TickW'(1);
        endcase
        len_eff   = (len_raw == '0) ? TickW'(1) : len_raw;
        tc_inc    = s_tc + TickW'(1);
        tm_done   = tc_inc >= len_eff;
        pres_hit  = !i_item.line_level && (s_tc < TickW'(i_cfg.presence_wait_limit));
        pres_fail = tc_inc >= TickW'(i_cfg.presence_wait_limit);
        rel_hit   = i_item.line_level && (s_tc < TickW'(i_cfg.release_wait_limit));
        rel_fail  = tc_inc >= TickW'(i_cfg.release_wait_limit);
        rd_sd     = (s_tc == '0) ? {i_item.line_level, s_sd[7:1]} : s_sd;
        last_bit  = s_bi == 3'd7;
    end

    // next phase
    always_comb begin
        case (s_ph)
            PH_RHIGH:  n_phase = tm_done ? PH_RLOW : PH_RHIGH;
            PH_RLOW:   n_phase = tm_done ? PH_PRES : PH_RLOW;
            PH_PRES:   n_phase = pres_hit ? PH_REL : (pres_fail ? PH_IDLE : PH_PRES);
            PH_REL:    n_phase = (rel_hit || rel_fail) ? PH_IDLE : PH_REL;
            PH_WLOW:   n_phase = tm_done ? PH_WHOLD : PH_WLOW;
            PH_WHOLD:  n_phase = tm_done ? (last_bit ? PH_IDLE : PH_WLOW) : PH_WHOLD;
            PH_RDLOW:  n_phase = tm_done ? PH_RDWAIT : PH_RDLOW;
            PH_RDWAIT: n_phase = tm_done ? PH_RDREC : PH_RDWAIT;
            PH_RDREC:  n_phase = tm_done ? (last_bit ? PH_IDLE : PH_RDLOW) : PH_RDREC;
            default:   n_phase = PH_IDLE;
        endcase
    end

    // counters, shifter, line drive and flags
    always_comb begin
        n_tc      = s_tc;
        n_bit_idx = s_bi;
        n_shift   = s_sd;
        n_pres    = r_pres;
        n_rd_byte = r_rd_byte;
        drive     = 1'b0;
        done      = 1'b0;
        case (s_ph)
            PH_RHIGH, PH_RDWAIT: begin
                n_tc = tm_done ? '0 : tc_inc;
            end
            PH_RLOW, PH_WLOW, PH_RDLOW: begin
                drive = 1'b1;
                n_tc  = tm_done ? '0 : tc_inc;
            end
            PH_PRES: begin
                if (pres_hit) begin
                    n_tc = '0;
                end else if (pres_fail) begin
                    n_pres    = 1'b0;
                    n_tc      = '0;
                    n_bit_idx = '0;
                    done      = 1'b1;
                end else begin
                    n_tc = tc_inc;
                end
            end
            PH_REL: begin
                if (rel_hit || rel_fail) begin
                    n_pres    = rel_hit;
                    n_tc      = '0;
                    n_bit_idx = '0;
                    done      = 1'b1;
                end else begin
                    n_tc = tc_inc;
                end
            end
            PH_WHOLD: begin
                drive = !s_sd[0];
                n_tc  = tm_done ? '0 : tc_inc;
                if (tm_done) begin
                    n_shift = {1'b0, s_sd[7:1]};
                    if (last_bit) begin
                        n_bit_idx = '0;
                        done      = 1'b1;
                    end else begin
                        n_bit_idx = s_bi + 3'd1;
                    end
                end
            end
            PH_RDREC: begin
                n_shift = rd_sd;
                n_tc    = tm_done ? '0 : tc_inc;
                if (tm_done) begin
                    if (last_bit) begin
                        n_rd_byte = rd_sd;
                        n_bit_idx = '0;
                        done      = 1'b1;
                    end else begin
                        n_bit_idx = s_bi + 3'd1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_res.drive_low   = drive;
        o_res.busy_res    = n_phase != PH_IDLE;
        o_res.done_res    = done;
        o_res.presence_ok = n_pres;
        o_res.read_data   = n_rd_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_tc      <= '0;
            r_bit_idx <= '0;
            r_shift   <= '0;
            r_pres    <= 1'b0;
            r_rd_byte <= '0;
        end else if (i_en) begin
            r_phase   <= n_phase;
            r_tc      <= n_tc;
            r_bit_idx <= n_bit_idx;
            r_shift   <= n_shift;
            r_pres    <= n_pres;
            r_rd_byte <= n_rd_byte;
        end
    end

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && o_res.done_res |-> !o_res.busy_res)
        else $error("done reported while still busy");

    a_idle_no_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && r_phase == PH_IDLE && !cmd_ok |-> !o_res.busy_res && !o_res.done_res)
        else $error("activity without a command");

    a_idle_bit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_IDLE |-> r_bit_idx == '0 && r_tc == '0)
        else $error("counters not cleared in idle");

    a_done_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && o_res.done_res |=> r_phase == PH_IDLE)
        else $error("phase not idle after done");

endmodule

// ===== rtl/one_wire_byte_master.sv =====
// top level: stream channels, config registers and output register
`timescale 1ns / 1ps
//
// 1-wire bus master stepped once per input beat; each beat is one time tick.
// input stream: each beat carries the sampled line level and, while idle,
// an optional command (reset/presence, write byte, read byte).
// output stream: exactly one beat per input beat, giving line drive, busy,
// done, presence result of the last reset and the last read byte.
// config channel: index/data writes to the eight timing registers; always
// ready, writes to be made while no command runs.
// timing: the result of a tick appears on the output register in the cycle
// after its input beat is taken. throughput: one tick per cycle unless the output
// stalls, set by the combinational phase/counter update between input and output register.
// reset: line released, phase idle, presence and read byte zero, timing
// registers at their defaults, output empty.
// stall: while the output beat waits, a new input beat is taken only in the
// cycle that the output beat leaves; otherwise input ready drops.
//

module one_wire_byte_master (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // start_req, operation[1:0], write_data[7:0], line_level, zero pad
    input  logic [owbm_pkg::InTdataW-1:0]   i_s_axis_tdata,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // drive_low, busy_res, done_res, presence_ok, read_data[7:0], zero pad
    output logic [owbm_pkg::OutTdataW-1:0]  o_m_axis_tdata,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [owbm_pkg::CfgIdxW-1:0]    i_cfg_index,
    input  logic [owbm_pkg::CfgDataW-1:0]   i_cfg_data
);
    import owbm_pkg::*;

    t_cfg  r_cfg;
    t_item item;
    t_res  res;
    logic  in_beat;
    logic  r_out_valid;
    t_res  r_out;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign in_beat         = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        item.start_req  = i_s_axis_tdata[0];
        item.operation  = i_s_axis_tdata[2:1];
        item.write_data = i_s_axis_tdata[10:3];
        item.line_level = i_s_axis_tdata[11];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CfgReset;
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_IDLE_HIGH:    r_cfg.idle_high_ticks     <= i_cfg_data[3:0];
                REG_RESET_LOW:    r_cfg.reset_low_ticks     <= i_cfg_data[9:0];
                REG_PRES_WAIT:    r_cfg.presence_wait_limit <= i_cfg_data[7:0];
                REG_REL_WAIT:     r_cfg.release_wait_limit  <= i_cfg_data[7:0];
                REG_SLOT_LOW:     r_cfg.slot_low_ticks      <= i_cfg_data[3:0];
                REG_WRITE_HOLD:   r_cfg.write_hold_ticks    <= i_cfg_data[7:0];
                REG_READ_SAMPLE:  r_cfg.read_sample_ticks   <= i_cfg_data[3:0];
                REG_READ_RECOVER: r_cfg.read_recovery_ticks <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    owbm_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (in_beat),
        .i_cfg   (r_cfg),
        .i_item  (item),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_beat) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'b0000, r_out.read_data, r_out.presence_ok,
                              r_out.done_res, r_out.busy_res, r_out.drive_low};

    a_beat_gives_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> o_m_axis_tvalid)
        else $error("input beat produced no output beat");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid && !i_m_axis_tready)
        else $error("input stalled with room in output register");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("output changed while stalled");

endmodule
